>>> hw/rtl/elbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package elbs_pkg;

    // Field widths
    localparam int TS_W        = 11;
    localparam int POS_W       = 10;
    localparam int VAL_W       = 32;
    localparam int IDX_W       = 11;

    // Default table depth
    localparam int MAX_ENTRIES_DEF = 1024;

    // Request operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load_write;   // write one table entry
        logic load_query;   // capture key and effective size
        logic probe_step;   // evaluate one exponential probe
        logic bin_issue;    // read at the bracket midpoint
        logic bin_step;     // narrow the bracket
        logic finish;       // latch the answer
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic n_zero;       // effective size is zero
        logic probe_more;   // keep doubling the bound
        logic bin_open;     // bracket still holds candidates
    } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/elbs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module elbs_datapath #(
    parameter int MAX_ENTRIES = elbs_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire elbs_pkg::cmd_t                cmd,
    output elbs_pkg::status_t                  status,
    input  wire logic [elbs_pkg::POS_W-1:0]    position,
    input  wire logic signed [elbs_pkg::VAL_W-1:0] query_value,
    input  wire logic                          cfg_valid,
    input  wire logic [elbs_pkg::TS_W-1:0]     cfg_data,
    output logic [elbs_pkg::IDX_W-1:0]         found_index
);
    import elbs_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int BW = CW + 1;
    localparam int PW = (POS_W > AW) ? POS_W : AW;

    logic [TS_W-1:0]         table_size_reg;
    logic signed [VAL_W-1:0] mem [MAX_ENTRIES];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic signed [VAL_W-1:0] key_reg;
    logic [CW-1:0]           n_reg;
    logic [BW-1:0]           bound_reg;
    logic [CW-1:0]           lo_reg;
    logic [CW-1:0]           hi_reg;
    logic [CW-1:0]           mid_reg;
    logic [IDX_W-1:0]        found_reg;

    logic [31:0]             ts_w;
    logic [31:0]             n_w;
    logic [PW-1:0]           pos_ext;
    logic                    pos_ok;
    logic [AW-1:0]           rd_addr;
    logic                    ge;
    logic [BW-1:0]           bn;
    logic [CW-1:0]           diff;
    logic [CW-1:0]           mid;
    logic [31:0]             lo_w;

    // Size register, write channel always ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TS_W'(1);
        end
        else if (cfg_valid)
        begin
            table_size_reg <= cfg_data;
        end
    end

    // Effective size, saturated to the table depth
    assign ts_w = 32'(table_size_reg);
    assign n_w  = (ts_w > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : ts_w;

    // Load address check
    assign pos_ext = PW'(position);
    assign pos_ok  = (32'(position) < 32'(MAX_ENTRIES));

    // Entry compare against the key
    assign ge = (rd_data_reg >= key_reg);

    // Next probe bound; a hit keeps the bound, position 0 steps to 1
    always_comb
    begin
        if (ge)
        begin
            bn = bound_reg;
        end
        else if (bound_reg == '0)
        begin
            bn = BW'(1);
        end
        else
        begin
            bn = bound_reg << 1;
        end
    end

    // Bracket midpoint
    assign diff = hi_reg - lo_reg;
    assign mid  = lo_reg + (diff >> 1);

    // Table read address
    assign rd_addr = cmd.bin_issue ? mid[AW-1:0] : bound_reg[AW-1:0];

    // Table storage, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_write && pos_ok)
        begin
            mem[pos_ext[AW-1:0]] <= query_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Search registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            key_reg   <= query_value;
            n_reg     <= n_w[CW-1:0];
            bound_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end
        else if (cmd.probe_step)
        begin
            bound_reg <= bn;
            lo_reg    <= bn[BW-1:1];
            hi_reg    <= (bn < {1'b0, n_reg}) ? bn[CW-1:0] : n_reg;
        end
        else if (cmd.bin_issue)
        begin
            mid_reg <= mid;
        end
        else if (cmd.bin_step)
        begin
            if (ge)
            begin
                hi_reg <= mid_reg;
            end
            else
            begin
                lo_reg <= mid_reg + CW'(1);
            end
        end
    end

    // Answer register
    assign lo_w = 32'(lo_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            found_reg <= lo_w[IDX_W-1:0];
        end
    end

    assign found_index = found_reg;

    // Status to controller
    assign status.n_zero     = (n_w == 32'd0);
    assign status.probe_more = !ge && (bn < {1'b0, n_reg});
    assign status.bin_open   = (lo_reg < hi_reg);

endmodule

`default_nettype wire

>>> hw/rtl/elbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module elbs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              op,
    input  wire elbs_pkg::status_t status,
    output elbs_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   done
);
    import elbs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_PROBE_RD  = 5'b00010,
        S_PROBE_CMP = 5'b00100,
        S_BIN       = 5'b01000,
        S_BIN_CMP   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // State and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Sequencing: probe read/compare pairs, then bisection read/compare pairs
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = status.n_zero ? S_BIN : S_PROBE_RD;
                    end
                    else
                    begin
                        cmd.load_write = 1'b1;
                    end
                end
            end
            S_PROBE_RD:
            begin
                state_next = S_PROBE_CMP;
            end
            S_PROBE_CMP:
            begin
                cmd.probe_step = 1'b1;
                state_next     = status.probe_more ? S_PROBE_RD : S_BIN;
            end
            S_BIN:
            begin
                if (status.bin_open)
                begin
                    cmd.bin_issue = 1'b1;
                    state_next    = S_BIN_CMP;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_BIN_CMP:
            begin
                cmd.bin_step = 1'b1;
                state_next   = S_BIN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/exponential_lower_bound_search.sv
`timescale 1ns / 1ps
`default_nettype none

// Lower-bound search over a sorted table of signed 32-bit values. A request with
// op = load writes query_value at position without raising busy; positions at or
// beyond MAX_ENTRIES are dropped. A request with op = query returns, on found_index
// with a one-cycle done strobe, the first position below table_size whose entry is
// at least query_value, else table_size (saturated to MAX_ENTRIES). The search
// probes positions 0, 1, 2, 4, 8 and so on, then bisects the last bracket. Every
// table read goes through the single memory port with a registered read, so each
// probe and each bisection step is a read state followed by a compare state.
// Requests are taken while busy is low; done may coincide with the next request.
// The receiver cannot stall: found_index is valid only in the cycle done is high.
// table_size is written through the cfg channel (always ready); the user must
// write it only while no query is in flight, as the block does not enforce this.
// table_size resets to 1. Queries must only touch entries written since reset.
module exponential_lower_bound_search #(
    parameter int MAX_ENTRIES = elbs_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              op,
    input  wire logic [elbs_pkg::POS_W-1:0]        position,
    input  wire logic signed [elbs_pkg::VAL_W-1:0] query_value,
    output logic                                   done,
    output logic [elbs_pkg::IDX_W-1:0]             found_index,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [elbs_pkg::TS_W-1:0]         cfg_data
);
    import elbs_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    busy_int;

    // Size register takes writes at any time
    assign cfg_ready = 1'b1;

    elbs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy_int),
        .done   (done)
    );

    elbs_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .position    (position),
        .query_value (query_value),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .found_index (found_index)
    );

    assign busy = busy_int;

endmodule

`default_nettype wire

>>> hw/rtl/elbs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module elbs_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              op,
    input wire logic                              done,
    input wire logic [elbs_pkg::IDX_W-1:0]        found_index
);
    import elbs_pkg::*;

    // A result only ever ends a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a preceding busy cycle");

    // Results are single-cycle strobes
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // An accepted query starts a search
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_QUERY) |=> busy)
        else $error("query request did not raise busy");

    // A load completes at once and gives no result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_LOAD) |=> (!busy && !done))
        else $error("load request produced busy or a result");

    // The answer is fully defined whenever it is presented
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(found_index))
        else $error("found_index unknown while done is high");

endmodule

bind exponential_lower_bound_search elbs_checker u_elbs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .done        (done),
    .found_index (found_index)
);

`default_nettype wire

>>> test/tb_exponential_lower_bound_search.sv
`timescale 1ns / 1ps

module tb_exponential_lower_bound_search;

    import elbs_pkg::*;

    localparam int TABLE_DEPTH   = MAX_ENTRIES_DEF;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic                    op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } request_t;

    // DUT ports
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    op = OP_LOAD;
    logic [POS_W-1:0]        position = '0;
    logic signed [VAL_W-1:0] query_value = '0;
    logic                    done;
    logic [IDX_W-1:0]        found_index;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [TS_W-1:0]         cfg_data = '0;

    // stimulus side
    request_t                pending_requests[$];
    logic signed [VAL_W-1:0] loaded_values [TABLE_DEPTH];
    int                      pushed_items = 0;
    int                      burst_left = 1;
    int                      gap_left = 0;

    // prediction and checking side
    logic signed [VAL_W-1:0] entry_mirror [TABLE_DEPTH];
    logic [TS_W-1:0]         size_mirror = 11'd1;
    logic [IDX_W-1:0]        expected_index[$];
    logic [IDX_W-1:0]        want_index;
    int                      load_count = 0;
    int                      query_count = 0;
    int                      size_writes = 0;
    int                      answers_checked = 0;
    int                      error_count = 0;
    int                      cycle_count = 0;

    exponential_lower_bound_search #(
        .MAX_ENTRIES (TABLE_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .position    (position),
        .query_value (query_value),
        .done        (done),
        .found_index (found_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Expected answer: probe 1, 2, 4, ... then bisect the last bracket
    function automatic logic [IDX_W-1:0] lower_bound(input logic signed [VAL_W-1:0] key);
        int unsigned n;
        int unsigned bound;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        n = 32'(size_mirror);
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        if (n == 0)
            return '0;
        if (entry_mirror[0] >= key)
            return '0;
        bound = 1;
        while (bound < n && entry_mirror[bound] < key)
            bound = bound << 1;
        lo = bound >> 1;
        hi = (bound < n) ? bound : n;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (entry_mirror[mid] >= key)
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo[IDX_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_value(input longint v);
        if (v > VAL_MAX)
            return VAL_MAX;
        if (v < VAL_MIN)
            return VAL_MIN;
        return v[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] random_value();
        return int'($urandom);
    endfunction

    // Query key: extremes, near a loaded entry, or anywhere
    function automatic logic signed [VAL_W-1:0] pick_key(input int n);
        longint k;
        case ($urandom_range(0, 9))
            0: k = longint'(VAL_MIN);
            1: k = longint'(VAL_MAX);
            2, 3, 4, 5:
            begin
                if (n > 0)
                    k = longint'(loaded_values[$urandom_range(0, n - 1)])
                        + int'($urandom_range(0, 2)) - 1;
                else
                    k = longint'(random_value());
            end
            default: k = longint'(random_value());
        endcase
        return clamp_value(k);
    endfunction

    task automatic push_load(input int pos, input logic signed [VAL_W-1:0] value);
        request_t req;
        req.op       = OP_LOAD;
        req.position = pos[POS_W-1:0];
        req.value    = value;
        loaded_values[pos] = value;
        pending_requests.push_back(req);
        pushed_items++;
    endtask

    task automatic push_query(input logic signed [VAL_W-1:0] key);
        request_t req;
        req.op       = OP_QUERY;
        req.position = POS_W'($urandom_range(0, TABLE_DEPTH - 1));
        req.value    = key;
        pending_requests.push_back(req);
        pushed_items++;
    endtask

    // Fill positions 0..n-1, ascending with random steps or in random order
    task automatic fill_table(input int n, input bit ascending);
        longint      v;
        int unsigned step_max;
        case ($urandom_range(0, 2))
            0: step_max = 3;
            1: step_max = 1000;
            default: step_max = 1 << 22;
        endcase
        v = ($urandom_range(0, 3) == 0) ? longint'(VAL_MIN) : longint'(random_value());
        for (int i = 0; i < n; i++)
        begin
            if (ascending)
            begin
                push_load(i, clamp_value(v));
                v = v + longint'($urandom_range(0, step_max));
            end
            else
                push_load(i, random_value());
        end
    endtask

    // Everything sent, answered, and the block quiet again
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || start || expected_index.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_table_size(input int size);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= size[TS_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Request driver: bursts of random length with random gaps
    always @(posedge clk)
    begin
        request_t req;
        if (rst_n && (!start || !busy))
        begin
            if (gap_left > 0 || pending_requests.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                start <= 1'b0;
            end
            else
            begin
                req = pending_requests.pop_front();
                start       <= 1'b1;
                op          <= req.op;
                position    <= req.position;
                query_value <= req.value;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end
                else
                    burst_left--;
            end
        end
    end

    // Monitor: track config and table, predict on accept, check on done
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                size_mirror = cfg_data;
                size_writes++;
            end
            if (start && !busy)
            begin
                if (op == OP_QUERY)
                begin
                    expected_index.push_back(lower_bound(query_value));
                    query_count++;
                end
                else
                begin
                    if (position < TABLE_DEPTH)
                        entry_mirror[position] = query_value;
                    load_count++;
                end
            end
            if (done)
            begin
                if (expected_index.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual found_index %0d",
                             $time, found_index);
                    error_count++;
                end
                else
                begin
                    want_index = expected_index.pop_front();
                    answers_checked++;
                    if (found_index !== want_index)
                    begin
                        $display("%0t: found_index mismatch: expected %0d, actual %0d",
                                 $time, want_index, found_index);
                        error_count++;
                    end
                end
            end
        end
    end

    // Hard stop
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("[exponential_lower_bound_search] ERROR");
            $finish;
        end
    end

    initial
    begin
        int size;
        int n;
        int first_random;
        bit ascending;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // size 1 after reset: below, equal, above the single entry
        push_load(0, 32'sd0);
        push_query(VAL_MIN);
        push_query(32'sd0);
        push_query(32'sd1);
        push_query(VAL_MAX);

        // empty table answers 0
        write_table_size(0);
        push_query(32'sd12345);
        push_query(VAL_MIN);

        // extremes and duplicates in a short sorted table
        write_table_size(5);
        push_load(0, VAL_MIN);
        push_load(1, -32'sd7);
        push_load(2, -32'sd7);
        push_load(3, 32'sd100);
        push_load(4, VAL_MAX);
        push_query(VAL_MIN);
        push_query(-32'sd8);
        push_query(-32'sd7);
        push_query(32'sd0);
        push_query(32'sd101);
        push_query(VAL_MAX);

        // unsorted table: answer follows the probe order
        write_table_size(4);
        push_load(0, 32'sd50);
        push_load(1, -32'sd3);
        push_load(2, 32'sd80);
        push_load(3, 32'sd10);
        push_query(32'sd60);
        push_query(32'sd10);
        push_query(-32'sd100);

        first_random = pushed_items;

        // full table, then sizes past the depth that saturate
        write_table_size(TABLE_DEPTH);
        fill_table(TABLE_DEPTH, 1'b1);
        repeat (60) push_query(pick_key(TABLE_DEPTH));
        write_table_size(2047);
        repeat (20) push_query(pick_key(TABLE_DEPTH));
        write_table_size($urandom_range(TABLE_DEPTH + 1, 2046));
        repeat (20) push_query(pick_key(TABLE_DEPTH));

        // mostly small tables, some medium, some empty or minimal
        while (pushed_items - first_random < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: size = 0;
                1: size = 1;
                2: size = 2;
                3: size = $urandom_range(41, 300);
                default: size = $urandom_range(3, 40);
            endcase
            write_table_size(size);
            n = size;
            ascending = ($urandom_range(0, 4) != 0);
            fill_table(n, ascending);
            repeat ($urandom_range(4, 30))
            begin
                // occasional stray load, possibly breaking the order
                if ($urandom_range(0, 9) == 0)
                    push_load($urandom_range(0, TABLE_DEPTH - 1), random_value());
                else
                    push_query(pick_key(n));
            end
        end

        wait_idle();
        $display("Ran %0d loads and %0d queries over %0d table-size writes,",
                 load_count, query_count, size_writes);
        $display("sizes 0 to 2047 with sorted and unsorted tables; %0d answers checked.",
                 answers_checked);
        if (error_count == 0)
            $display("[exponential_lower_bound_search] OK");
        else
            $display("[exponential_lower_bound_search] ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/elbs_pkg.sv
hw/rtl/elbs_datapath.sv
hw/rtl/elbs_ctrl.sv
hw/rtl/exponential_lower_bound_search.sv
hw/rtl/elbs_checker.sv
test/tb_exponential_lower_bound_search.sv
